// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the hex line decoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define HLTB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define HLTB_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/hltb_pkg.sv -----
// ----------------------------------------------------------------------------
// hltb_pkg
// types, character codes and decode helpers for the hex line decoder
// ----------------------------------------------------------------------------
package hltb_pkg;

  localparam int unsigned StoreDepth = 63;
  localparam int unsigned CountW     = 6;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChVtab    = 8'h0B;
  localparam logic [7:0] ChFfeed   = 8'h0C;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChLbrack  = 8'h5B;
  localparam logic [7:0] ChRbrack  = 8'h5D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] ChLoA     = 8'h61;
  localparam logic [7:0] ChLoF     = 8'h66;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  // one unit of work handed from front to back
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       close;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic emitting;
    logic rd_pending;
  } back_stat_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= ChZero && c <= ChNine) begin
      v = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpF) begin
      v = c - ChUpA + 8'd10;
    end else if (c >= ChLoA && c <= ChLoF) begin
      v = c - ChLoA + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNewline) ||
           (c == ChVtab) || (c == ChFfeed) || (c == ChCr);
  endfunction

endpackage

// ----- design/hltb_front.sv -----
// ----------------------------------------------------------------------------
// hltb_front
// accepts characters, tracks segment state and issues byte and close commands
// ----------------------------------------------------------------------------
module hltb_front #(
  parameter int unsigned SEG_CHARS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_text_i,
  output logic              cmd_push_o,
  output hltb_pkg::cmd_t    cmd_o
);

  localparam int unsigned SegW = $clog2(SEG_CHARS);

  logic [SegW-1:0] seg_cnt_q, seg_cnt_d;
  logic [3:0]      hn_q, hn_d;
  logic            half_q, half_d;
  logic            colon_q, colon_d;
  logic            bracket_q, bracket_d;
  logic            zero_q, zero_d;

  logic [3:0]      nib;
  logic [SegW:0]   cnt_inc;
  logic [3:0]      hn_n;
  logic            half_n, colon_n, bracket_n, zero_n;
  logic            byte_push;
  hltb_pkg::cmd_t  cmd;

  assign nib     = hltb_pkg::hex_nibble(char_code_i);
  assign cnt_inc = {1'b0, seg_cnt_q} + {{SegW{1'b0}}, 1'b1};

  always_comb begin
    seg_cnt_d = seg_cnt_q;
    hn_d      = hn_q;
    half_d    = half_q;
    colon_d   = colon_q;
    bracket_d = bracket_q;
    zero_d    = zero_q;
    hn_n      = hn_q;
    half_n    = half_q;
    colon_n   = colon_q;
    bracket_n = bracket_q;
    zero_n    = zero_q;
    byte_push = 1'b0;
    cmd       = '0;

    if (end_of_text_i) begin
      cmd.close    = 1'b1;
      cmd.emit     = colon_q & ~bracket_q;
      cmd.has_byte = colon_q & ~bracket_q & half_q;
      cmd.data     = {hn_q, 4'h0};
    end else begin
      if (!zero_q && char_code_i != hltb_pkg::ChNewline) begin
        if (char_code_i == hltb_pkg::ChNul) begin
          zero_n = 1'b1;
        end else begin
          if (char_code_i == hltb_pkg::ChLbrack || char_code_i == hltb_pkg::ChRbrack) begin
            bracket_n = 1'b1;
          end
          if (!colon_q && char_code_i == hltb_pkg::ChColon) begin
            colon_n = 1'b1;
          end else if (colon_q && !hltb_pkg::is_blank(char_code_i)) begin
            if (half_q) begin
              byte_push = 1'b1;
              half_n    = 1'b0;
              hn_n      = 4'h0;
            end else begin
              hn_n   = nib;
              half_n = 1'b1;
            end
          end
        end
      end
      cmd.close = (char_code_i == hltb_pkg::ChNewline) ||
                  (cnt_inc == (SegW+1)'(SEG_CHARS - 1));
      cmd.emit  = colon_n & ~bracket_n;
      // a lone trailing digit is flushed as a high nibble at segment end
      cmd.has_byte = byte_push | (cmd.close & cmd.emit & half_n);
      cmd.data     = byte_push ? {hn_q, nib} : {hn_n, 4'h0};
    end

    if (accept_i) begin
      if (cmd.close) begin
        seg_cnt_d = '0;
        hn_d      = 4'h0;
        half_d    = 1'b0;
        colon_d   = 1'b0;
        bracket_d = 1'b0;
        zero_d    = 1'b0;
      end else begin
        seg_cnt_d = cnt_inc[SegW-1:0];
        hn_d      = hn_n;
        half_d    = half_n;
        colon_d   = colon_n;
        bracket_d = bracket_n;
        zero_d    = zero_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q <= '0;
      hn_q      <= 4'h0;
      half_q    <= 1'b0;
      colon_q   <= 1'b0;
      bracket_q <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      seg_cnt_q <= seg_cnt_d;
      hn_q      <= hn_d;
      half_q    <= half_d;
      colon_q   <= colon_d;
      bracket_q <= bracket_d;
      zero_q    <= zero_d;
    end
  end

  assign cmd_push_o = accept_i & (cmd.has_byte | cmd.close);
  assign cmd_o      = cmd;

endmodule

// ----- design/hltb_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// hltb_cmd_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module hltb_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hltb_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output hltb_pkg::cmd_t data_o,
  output logic           empty_o
);

  hltb_pkg::cmd_t slot_q [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           head_q, head_d;
  logic           tail;
  logic           do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign tail    = head_q ^ cnt_q[0];
  assign data_o  = slot_q[head_q];

  always_comb begin
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    head_d = head_q ^ do_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[tail] <= data_i;
    end
  end

endmodule

// ----- design/hltb_back.sv -----
// ----------------------------------------------------------------------------
// hltb_back
// byte store, segment commit and result streaming
// ----------------------------------------------------------------------------
module hltb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  hltb_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  output hltb_pkg::back_stat_t stat_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [7:0]           data_byte_o,
  output logic                 last_byte_o
);

  localparam int unsigned CW = hltb_pkg::CountW;

  hltb_pkg::back_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] new_cnt;
  logic          wr_en;
  logic          issue, issue_last;
  logic          rd_vld_q, rd_last_q;
  logic [7:0]    rdata_q;

  logic [7:0]    store_mem [hltb_pkg::StoreDepth];

  logic [7:0]    obyte_q [2];
  logic          olast_q [2];
  logic [1:0]    ocnt_q;
  logic          ohead_q;
  logic          otail;
  logic          opop;

  assign cmd_pop_o  = (state_q == hltb_pkg::BK_IDLE) & cmd_valid_i;
  assign wr_en      = cmd_pop_o & cmd_i.has_byte &
                      (count_q < CW'(hltb_pkg::StoreDepth));
  assign new_cnt    = count_q + {{(CW-1){1'b0}}, wr_en};
  assign issue      = (state_q == hltb_pkg::BK_EMIT) &
                      ((ocnt_q + {1'b0, rd_vld_q}) < 2'd2);
  assign issue_last = (rd_idx_q == total_q - CW'(1));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    total_d  = total_q;
    rd_idx_d = rd_idx_q;
    unique case (state_q)
      hltb_pkg::BK_IDLE: begin
        if (cmd_pop_o) begin
          count_d = new_cnt;
          if (cmd_i.close) begin
            count_d = '0;
            if (cmd_i.emit && new_cnt != '0) begin
              total_d  = new_cnt;
              rd_idx_d = '0;
              state_d  = hltb_pkg::BK_EMIT;
            end
          end
        end
      end
      hltb_pkg::BK_EMIT: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
          if (issue_last) begin
            state_d = hltb_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = hltb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hltb_pkg::BK_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[count_q] <= cmd_i.data;
    end
    if (issue) begin
      rdata_q   <= store_mem[rd_idx_q];
      rd_last_q <= issue_last;
    end
  end

  // result buffer, room is reserved before a read is issued
  assign opop  = pop_i & (ocnt_q != 2'd0);
  assign otail = ohead_q ^ ocnt_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q  <= 2'd0;
      ohead_q <= 1'b0;
    end else begin
      ocnt_q  <= ocnt_q + {1'b0, rd_vld_q} - {1'b0, opop};
      ohead_q <= ohead_q ^ opop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      obyte_q[otail] <= rdata_q;
      olast_q[otail] <= rd_last_q;
    end
  end

  assign empty_o     = (ocnt_q == 2'd0);
  assign data_byte_o = obyte_q[ohead_q];
  assign last_byte_o = olast_q[ohead_q];

  assign stat_o.emitting   = (state_q == hltb_pkg::BK_EMIT);
  assign stat_o.rd_pending = rd_vld_q;

endmodule

// ----- design/hex_line_to_bytes_core.sv -----
// ----------------------------------------------------------------------------
// hex_line_to_bytes_core
// hex text line decoder: characters in, decoded bytes of valid segments out
// ----------------------------------------------------------------------------
// The block takes one character per item and decodes the text after the first
// colon of each segment into bytes, two hex digits per byte, whitespace
// dropped. A segment closes on a newline, after SEG_CHARS-1 characters or on
// an end_of_text item; its bytes come out only if it held a colon and no
// bracket, the final one flagged by last_byte. The front takes one character
// per cycle as long as the two-entry command queue has room. The back takes
// a queued command only while idle and, at a closing segment that emits
// bytes, streams them out of its byte store through its single read port,
// taking no commands meanwhile; its two-entry result buffer takes a new
// read only while it and the read in flight hold fewer than two bytes. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_line_to_bytes_core #(
  parameter int unsigned SEG_CHARS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // character side
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       last_byte_o
);

  logic                 accept;
  logic                 cmd_push;
  hltb_pkg::cmd_t       cmd_in;
  hltb_pkg::cmd_t       cmd_out;
  logic                 cmd_full;
  logic                 cmd_empty;
  logic                 cmd_pop;
  hltb_pkg::back_stat_t bk_stat;

  // an item is taken whenever the command queue can hold what it may produce
  assign full   = cmd_full;
  assign accept = push & ~cmd_full;

  // front: segment tracking and digit pairing
  hltb_front #(
    .SEG_CHARS (SEG_CHARS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  // decoupling queue, lets the front keep going while the back streams
  hltb_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: byte store and result stream
  hltb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (~cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .stat_o      (bk_stat),
    .empty_o     (empty),
    .pop_i       (pop),
    .data_byte_o (data_byte_o),
    .last_byte_o (last_byte_o)
  );

  // the front never drops a command into a full queue
  `HLTB_ASSERT(a_no_cmd_overflow, clk_i, rst_ni, cmd_push |-> !cmd_full, "command queue overflow")

  // no new command is taken while a segment is being streamed out
  `HLTB_ASSERT(a_no_cmd_while_emit, clk_i, rst_ni, bk_stat.emitting |-> !cmd_pop, "command taken during emit")

  // a read in flight only follows a cycle of streaming
  `HLTB_ASSERT(a_read_from_emit, clk_i, rst_ni, bk_stat.rd_pending |-> $past(bk_stat.emitting), "read without emit")

  // nothing to deliver right after reset
  `HLTB_ASSERT_ALWAYS(a_empty_after_reset, clk_i, !rst_ni |=> empty, "result side not empty after reset")

endmodule
